>>> rtl/smrd_pkg.sv
// ----------------------------------------------------------------------------
// smrd_pkg: shared types and constants for the SplitMix64 range draw core
// Finalizer constants, retry limit and the controller/datapath command links.
// ----------------------------------------------------------------------------
package smrd_pkg;

  localparam logic [63:0] MUL_A  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MUL_B  = 64'hc4ceb9fe1a85ec53;
  localparam int          FOLD   = 33;
  localparam logic [63:0] LOW63  = 64'h7fffffffffffffff;
  localparam logic [63:0] SIGNBIT = 64'h8000000000000000;
  localparam int          RETRY_LIMIT = 64;

  localparam logic [1:0] MODE_BOOL = 2'd0;
  localparam logic [1:0] MODE_INT  = 2'd1;
  localparam logic [1:0] MODE_LOG  = 2'd2;

  // range classes for a uniform pick
  localparam logic [1:0] RK_MASK  = 2'd0;
  localparam logic [1:0] RK_MOD   = 2'd1;
  localparam logic [1:0] RK_REDRAW = 2'd2;

  typedef struct packed {
    logic load_req;    // capture lo/hi/mode, classify request
    logic draw_start;  // advance seed, start finalizer
    logic mod_start;   // start remainder unit on the masked draw
    logic judge;       // evaluate draw against the active range
    logic log_clamp;   // clamp bounds from drawn bit count
    logic log_setup;   // set range to bit lengths of lo and hi
    logic finish_err;
  } smrd_cmd_t;

  typedef struct packed {
    logic       req_bad;    // empty or unsupported request
    logic [1:0] req_mode;
    logic       draw_done;
    logic       mod_done;
    logic [1:0] range_kind;
    logic       accept;     // judged draw is inside
  } smrd_stat_t;

  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic sle(input logic [63:0] a, input logic [63:0] b);
    return (a ^ SIGNBIT) <= (b ^ SIGNBIT);
  endfunction

endpackage

>>> rtl/smrd_mix.sv
// ----------------------------------------------------------------------------
// smrd_mix: multi-cycle MurmurHash3 fmix64 finalizer
// Two 64-bit products, each split into 32x32 partial products over cycles.
// ----------------------------------------------------------------------------
module smrd_mix import smrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P0   = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;

  logic [3:0]  state;
  logic        round;       // 0: first multiply, 1: second
  logic [63:0] z;
  logic [63:0] acc;
  logic [63:0] pp;
  logic [63:0] mulk;
  logic [31:0] ma, mb;

  assign mulk = round ? MUL_B : MUL_A;

  always_comb begin
    ma = z[31:0];
    mb = mulk[31:0];
    unique case (state)
      S_P1:    begin ma = z[63:32]; mb = mulk[31:0];  end
      S_P2:    begin ma = z[31:0];  mb = mulk[63:32]; end
      default: begin ma = z[31:0];  mb = mulk[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      round <= 1'b0;
    end else begin
      done <= (state == S_FIN) && round;
      unique case (state)
        S_IDLE: if (start) begin
          z     <= din ^ (din >> FOLD);
          round <= 1'b0;
          state <= S_P0;
        end
        S_P0: state <= S_P1;
        S_P1: begin acc <= pp; state <= S_P2; end
        S_P2: begin acc <= acc + {pp[31:0], 32'd0}; state <= S_SUM; end
        S_SUM: begin acc <= acc + {pp[31:0], 32'd0}; state <= S_FIN; end
        S_FIN: begin
          if (!round) begin
            z     <= acc ^ (acc >> FOLD);
            round <= 1'b1;
            state <= S_P0;
          end else begin
            dout  <= acc ^ (acc >> FOLD);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/smrd_rem.sv
// ----------------------------------------------------------------------------
// smrd_rem: radix-2 restoring remainder unit
// 63-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smrd_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] rem
);

  logic        busy;
  logic [5:0]  cnt;
  logic [62:0] shreg;
  logic [64:0] trial;

  assign trial = {rem, shreg[62]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 6'd0);
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd62;
        shreg <= dividend;
        rem   <= 64'd0;
      end else if (busy) begin
        rem   <= trial[64] ? {rem[62:0], shreg[62]} : trial[63:0];
        shreg <= {shreg[61:0], 1'b0};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

endmodule

>>> rtl/smrd_datapath.sv
// ----------------------------------------------------------------------------
// smrd_datapath: seed, range registers and draw evaluation
// Holds the running seed, active range, finalizer and remainder units.
// ----------------------------------------------------------------------------
module smrd_datapath import smrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic        cfg_hit,
  input  logic [63:0] cfg_data,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_lo,
  input  logic [63:0] in_hi,
  input  smrd_cmd_t   cmd,
  output smrd_stat_t  stat,
  output logic [63:0] res_value,
  output logic [63:0] seed
);

  logic [63:0] gamma;
  logic [63:0] req_lo, req_hi;   // original request bounds
  logic [63:0] lo, hi;           // active uniform range
  logic [1:0]  mode;
  logic        bad;
  logic [63:0] draw, val;
  logic        mix_done, rem_done;
  logic [63:0] rem;
  logic [63:0] span;
  logic [63:0] masked;
  logic [63:0] nb;
  logic [63:0] floor_v, ceil_v;

  assign span   = hi - lo;
  assign masked = draw & LOW63;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed  <= 64'd0;
      gamma <= 64'd1;
    end else begin
      if (cfg_we && cfg_hit && !cfg_idx) seed <= cfg_data;
      else if (cfg_we && cfg_hit && cfg_idx) gamma <= cfg_data;
      if (cmd.draw_start) seed <= seed + gamma;
    end
  end

  smrd_mix u_mix (
    .clk(clk), .rst(rst), .start(cmd.draw_start), .din(seed + gamma),
    .done(mix_done), .dout(draw)
  );

  smrd_rem u_rem (
    .clk(clk), .rst(rst), .start(cmd.mod_start), .dividend(masked[62:0]),
    .divisor(span + 64'd1), .done(rem_done), .rem(rem)
  );

  always_comb begin
    nb      = val & 64'd63;
    floor_v = (nb == 64'd0) ? 64'd0 : (64'd1 << (nb[5:0] - 6'd1));
    ceil_v  = (64'd1 << nb[5:0]) - 64'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode   <= in_mode;
      req_lo <= in_lo;
      req_hi <= in_hi;
      lo     <= in_lo;
      hi     <= in_hi;
      unique case (in_mode)
        MODE_BOOL: bad <= 1'b0;
        MODE_INT:  bad <= !sle(in_lo, in_hi);
        MODE_LOG:  bad <= in_lo[63] || in_hi[63] || (in_lo > in_hi);
        default:   bad <= 1'b1;
      endcase
    end
    if (cmd.log_setup) begin
      lo <= 64'(bit_len(req_lo));
      hi <= 64'(bit_len(req_hi));
    end
    if (cmd.log_clamp) begin
      lo <= (floor_v > req_lo) ? floor_v : req_lo;
      hi <= (ceil_v < req_hi) ? ceil_v : req_hi;
    end
    if (cmd.judge) begin
      if (mode == MODE_BOOL) val <= {63'd0, draw[0]};
      else if (stat.range_kind == RK_MASK) val <= masked + lo;
      else if (stat.range_kind == RK_MOD) val <= rem + lo;
      else val <= draw;
    end
  end

  always_comb begin
    stat.req_bad   = bad;
    stat.req_mode  = mode;
    stat.draw_done = mix_done;
    stat.mod_done  = rem_done;
    if (span == LOW63)     stat.range_kind = RK_MASK;
    else if (span < LOW63) stat.range_kind = RK_MOD;
    else                   stat.range_kind = RK_REDRAW;
    unique case (stat.range_kind)
      RK_MASK: stat.accept = 1'b1;
      RK_MOD:  stat.accept = (masked - rem) <= (LOW63 - span);
      default: stat.accept = sle(lo, draw) && sle(draw, hi);
    endcase
  end

  assign res_value = (cmd.finish_err) ? 64'd0 : val;

endmodule

>>> rtl/smrd_ctrl.sv
// ----------------------------------------------------------------------------
// smrd_ctrl: request sequencer
// Steps draws, remainder and retries; two uniform picks for log mode.
// ----------------------------------------------------------------------------
module smrd_ctrl import smrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_err,
  input  smrd_stat_t stat,
  output smrd_cmd_t  cmd
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_CHECK = 3'd1;
  localparam logic [2:0] C_DRAW  = 3'd2;
  localparam logic [2:0] C_WMIX  = 3'd3;
  localparam logic [2:0] C_WREM  = 3'd4;
  localparam logic [2:0] C_JUDGE = 3'd5;
  localparam logic [2:0] C_CLAMP = 3'd6;
  localparam logic [2:0] C_OUT   = 3'd7;

  logic [2:0] state, state_next;
  logic [6:0] tries;
  logic       phase;   // log mode: 0 picking bit count, 1 picking value

  assign in_ready  = (state == C_IDLE);
  assign out_valid = (state == C_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      C_IDLE: if (in_valid) begin cmd.load_req = 1'b1; state_next = C_CHECK; end
      C_CHECK: begin
        if (stat.req_bad) state_next = C_OUT;
        else begin
          if (stat.req_mode == MODE_LOG && !phase) cmd.log_setup = 1'b1;
          state_next = C_DRAW;
        end
      end
      C_DRAW: begin cmd.draw_start = 1'b1; state_next = C_WMIX; end
      C_WMIX: if (stat.draw_done) begin
        if (stat.req_mode != MODE_BOOL && stat.range_kind == RK_MOD) begin
          cmd.mod_start = 1'b1;
          state_next = C_WREM;
        end else state_next = C_JUDGE;
      end
      C_WREM: if (stat.mod_done) state_next = C_JUDGE;
      C_JUDGE: begin
        if (stat.req_mode == MODE_BOOL || stat.accept) begin
          cmd.judge = 1'b1;
          state_next = (stat.req_mode == MODE_LOG && !phase) ? C_CLAMP : C_OUT;
        end else if (tries == 7'(RETRY_LIMIT)) state_next = C_OUT;
        else state_next = C_DRAW;
      end
      C_CLAMP: begin cmd.log_clamp = 1'b1; state_next = C_DRAW; end
      C_OUT: begin
        cmd.finish_err = out_err;
        if (out_ready) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      tries   <= 7'd0;
      phase   <= 1'b0;
      out_err <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_req) begin
        phase <= 1'b0; out_err <= 1'b0;
      end
      if (state == C_CHECK && stat.req_bad) out_err <= 1'b1;
      if (state == C_CHECK || cmd.log_clamp) tries <= 7'd0;
      if (cmd.draw_start) tries <= tries + 7'd1;
      if (cmd.log_clamp) phase <= 1'b1;
      if (state == C_JUDGE && stat.req_mode != MODE_BOOL && !stat.accept
          && tries == 7'(RETRY_LIMIT)) out_err <= 1'b1;
    end
  end

endmodule

>>> rtl/splitmix64_range_draw_core.sv
// ----------------------------------------------------------------------------
// splitmix64_range_draw_core: SplitMix64 bounded integer generator
// One request in, one result out; controller plus datapath.
// ----------------------------------------------------------------------------
// One request at a time. Each draw runs through the finalizer (two
// 64-bit products, each built from three 32x32 partial products, the high
// product being dropped); a bounded range also passes each draw through
// the bit-serial remainder unit. Each rejected draw is followed by another
// draw. Log mode runs two such picks with a clamp between them. Empty or
// unsupported requests answer with no draw. Up to 64 draws are tried per
// pick before the request ends with status 1. The result holds until its
// transfer; the next request is taken after that.
module splitmix64_range_draw_core import smrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [63:0] lo,
  input  logic [63:0] hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic        status,
  output logic [63:0] seed_now
);

  smrd_cmd_t  cmd;
  smrd_stat_t stat;
  logic       err;

  smrd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_err(err),
    .stat(stat), .cmd(cmd)
  );

  smrd_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_index[0]),
    .cfg_hit(1'b1), .cfg_data(cfg_data), .in_mode(mode), .in_lo(lo),
    .in_hi(hi), .cmd(cmd), .stat(stat), .res_value(value), .seed(seed_now)
  );

  assign status = err;

  // result stays put while waiting for its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result changed before transfer");
  // busy block never takes a new request
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while result pending");
  // error results carry zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> value == 64'd0)
    else $error("error result nonzero");

endmodule
